/* hdl/sac_pkg.sv */
// Package for the set-associative flow cache: sizes, payload structs and
// the command/status structs between controller and datapath. No dependencies.
package sac_pkg;

   localparam int WAYS      = 4;
   localparam int KEY_BYTES = 8;
   localparam int MAX_SETS  = 1024;

   localparam int KEY_W     = 64;
   localparam int PORT_W    = 4;
   localparam int AGE_W     = 8;
   localparam int CNT_W     = 11;
   localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int DIV_W     = 32;
   localparam int STEP_W    = $clog2(DIV_W + 1);
   localparam int SKEY_W    = KEY_BYTES * 8;

   localparam logic [AGE_W-1:0] AGE_MAX = '1;

   // Command codes
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   typedef struct packed {
      logic              command;
      logic [KEY_W-1:0]  flow_key;
      logic [PORT_W-1:0] insert_port;
   } req_type;

   typedef struct packed {
      logic [PORT_W-1:0] out_port;
      logic              hit;
   } rsp_type;

   // Controller -> datapath
   typedef struct packed {
      logic load;      // capture request, start divide
      logic div_step;  // one restoring divide step
      logic clr_wr;    // clear sweep write
      logic rd;        // read the set
      logic wr;        // write the set back, load result
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic div_done;
      logic clr_done;
   } sts_type;

endpackage

/* hdl/sac_ctrl.sv */
// Controller for the flow cache: clear sweep, divide, read, write back, result.
// Depends on sac_pkg.
module sac_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             rsp_busy,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sac_pkg::cmd_type cmd,
   input  sac_pkg::sts_type sts
);
   import sac_pkg::*;

   typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_DIV, ST_READ, ST_WRITE} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = rsp_busy;
            if (req_valid && !rsp_busy) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ST_READ;
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.wr       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/sac_dp.sv */
// Datapath for the flow cache: set-count register, serial divider, set
// memory with age update and victim pick, result register. Depends on sac_pkg.
module sac_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [sac_pkg::CNT_W-1:0] csr_wdata,
   input  sac_pkg::req_type         req_data,
   output sac_pkg::rsp_type         rsp_data,
   input  sac_pkg::cmd_type         cmd,
   output sac_pkg::sts_type         sts
);
   import sac_pkg::*;

   typedef struct packed {
      logic [SKEY_W-1:0] key;
      logic [PORT_W-1:0] port;
      logic [AGE_W-1:0]  age;
   } entry_type;

   // Set-count register, clamped to 1..MAX_SETS
   logic [CNT_W-1:0] set_count_ff;
   logic [CNT_W-1:0] sets_eff;
   always_ff @(posedge clock) begin
      if (reset) set_count_ff <= CNT_W'(1024);
      else if (csr_write) set_count_ff <= csr_wdata;
   end
   always_comb begin
      if (set_count_ff == '0) sets_eff = CNT_W'(1);
      else if (32'(set_count_ff) > 32'(MAX_SETS)) sets_eff = CNT_W'(MAX_SETS);
      else sets_eff = set_count_ff;
   end

   // Captured request
   logic              cmd_ff;
   logic [SKEY_W-1:0] key_ff;
   logic [PORT_W-1:0] port_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_data.command;
         key_ff  <= req_data.flow_key[SKEY_W-1:0];
         port_ff <= req_data.insert_port;
      end
   end

   // Restoring divider: one quotient bit per cycle, remainder is the set
   logic [DIV_W-1:0]  dvd_ff;
   logic [CNT_W-1:0]  div_ff;
   logic [CNT_W:0]    rem_ff, rem_sh;
   logic [STEP_W-1:0] step_ff;
   assign rem_sh = {rem_ff[CNT_W-1:0], dvd_ff[DIV_W-1]};
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dvd_ff  <= req_data.flow_key[DIV_W-1:0];
         div_ff  <= sets_eff;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff  <= {dvd_ff[DIV_W-2:0], 1'b0};
         rem_ff  <= (rem_sh >= {1'b0, div_ff}) ? rem_sh - {1'b0, div_ff} : rem_sh;
         step_ff <= step_ff + STEP_W'(1);
      end
   end
   assign sts.div_done = (step_ff == STEP_W'(DIV_W - 1));

   // Clear sweep counter
   logic [SET_W-1:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clr_wr) clr_ff <= clr_ff + SET_W'(1);
   end
   assign sts.clr_done = (clr_ff == SET_W'(MAX_SETS - 1));

   // Set memory: one row holds all ways
   entry_type mem [MAX_SETS][WAYS];
   entry_type row_ff [WAYS];
   entry_type row_in [WAYS];
   logic [SET_W-1:0] set_idx;
   logic [SET_W-1:0] wr_idx;
   assign set_idx = rem_ff[SET_W-1:0];
   assign wr_idx  = cmd.clr_wr ? clr_ff : set_idx;

   always_ff @(posedge clock) begin
      if (cmd.rd) row_ff <= mem[set_idx];
      if (cmd.clr_wr || cmd.wr) begin
         for (int w = 0; w < WAYS; w++)
            mem[wr_idx][w] <= cmd.clr_wr ? entry_type'('0) : row_in[w];
      end
   end

   // Update the row: age, match, victim
   logic [AGE_W-1:0]  aged [WAYS];
   logic [AGE_W-1:0]  best;
   logic [WAY_W-1:0]  victim;
   logic [PORT_W-1:0] hit_port;
   logic              hit_any;
   always_comb begin
      best     = '0;
      victim   = '0;
      hit_port = '0;
      hit_any  = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         aged[w] = (row_ff[w].age == AGE_MAX) ? AGE_MAX : row_ff[w].age + AGE_W'(1);
         row_in[w] = row_ff[w];
         if (cmd_ff == CMD_LOOKUP) begin
            if (row_ff[w].key == key_ff) begin
               hit_any  = 1'b1;
               hit_port = row_ff[w].port;
               row_in[w].age = '0;
            end else begin
               row_in[w].age = aged[w];
            end
         end else begin
            row_in[w].age = aged[w];
            if (aged[w] > best) begin
               best   = aged[w];
               victim = WAY_W'(w);
            end
         end
      end
      if (cmd_ff == CMD_INSERT) begin
         row_in[victim].key  = key_ff;
         row_in[victim].port = port_ff;
         row_in[victim].age  = '0;
      end
   end

   // Result register
   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         rsp_ff.out_port <= (cmd_ff == CMD_INSERT) ? port_ff : hit_port;
         rsp_ff.hit      <= (cmd_ff == CMD_LOOKUP) && hit_any;
      end
   end
   assign rsp_data = rsp_ff;

endmodule

/* hdl/set_assoc_flow_cache_core.sv */
// Top level of the set-associative flow cache: controller plus datapath.
// Depends on sac_pkg, sac_ctrl, sac_dp.
//
//   channel | ports                         | direction
//   request | req_valid req_stall req_data  | in
//   result  | rsp_valid rsp_stall rsp_data  | out
//   config  | csr_write csr_wdata           | in
//
// A request passes through accept, the remainder steps of the serial
// divider, a set read and a write back that loads the result register.
// After reset a clear pass writes zero to all 1024 sets, one per cycle,
// with req_stall high. A held result stalls only the next write back.
module set_assoc_flow_cache_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sac_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sac_pkg::rsp_type          rsp_data,
   input  logic                      csr_write,
   input  logic [sac_pkg::CNT_W-1:0] csr_wdata
);
   import sac_pkg::*;

   cmd_type cmd;
   sts_type sts;

   sac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_busy  (1'b0),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   sac_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

/* hdl/sac_checker.sv */
// Port checker for the flow cache core, bound to the top level.
// Depends on sac_pkg.
module sac_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sac_pkg::rsp_type rsp_data
);
   import sac_pkg::*;

   // A held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // An accepted request is not followed by a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result too early");

   // After accepting, the request side stalls while the item is worked
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request accepted during work");

   // Right after reset the clear pass holds off requests and no result shows
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_stall && !rsp_valid)
      else $error("request or result during clear pass");

endmodule

bind set_assoc_flow_cache_core sac_checker u_sac_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* tb/tb_top.sv */
// Testbench for set_assoc_flow_cache_core: random and directed lookups/inserts
// checked against a behavioral cache model held in a scoreboard class.
// Depends on sac_pkg and the cache RTL.
module tb_top;
   import sac_pkg::*;

   // Scoreboard: behavioral copy of the cache plus queue of expected responses
   class flow_cache_sb;
      logic [KEY_W-1:0]  keys  [MAX_SETS*WAYS];
      logic [PORT_W-1:0] ports [MAX_SETS*WAYS];
      logic [AGE_W-1:0]  ages  [MAX_SETS*WAYS];
      logic [CNT_W-1:0]  sets_cfg;
      rsp_type           pending [$];
      int                errors;
      int                checked;

      function void clear();
         foreach (keys[i]) begin
            keys[i] = '0;
            ports[i] = '0;
            ages[i] = '0;
         end
         sets_cfg = 11'd1024;
         pending.delete();
         errors = 0;
         checked = 0;
      endfunction

      function void set_sets(logic [CNT_W-1:0] v);
         sets_cfg = v;
      endfunction

      // Update the model for an accepted request and queue its response
      function void note_request(req_type r);
         int unsigned n, base, victim;
         logic [AGE_W-1:0] best;
         rsp_type o;
         n = sets_cfg;
         if (n == 0) n = 1;
         if (n > MAX_SETS) n = MAX_SETS;
         base = (r.flow_key[31:0] % n) * WAYS;
         o = '0;
         if (r.command == CMD_LOOKUP) begin
            for (int w = 0; w < WAYS; w++) begin
               if (keys[base+w] == r.flow_key) begin
                  o.out_port = ports[base+w];
                  o.hit = 1'b1;
                  ages[base+w] = '0;
               end else if (ages[base+w] != AGE_MAX) begin
                  ages[base+w]++;
               end
            end
         end else begin
            victim = 0;
            best = '0;
            for (int w = 0; w < WAYS; w++) begin
               if (ages[base+w] != AGE_MAX) ages[base+w]++;
               if (ages[base+w] > best) begin
                  best = ages[base+w];
                  victim = w;
               end
            end
            ages[base+victim] = '0;
            keys[base+victim] = r.flow_key;
            ports[base+victim] = r.insert_port;
            o.out_port = r.insert_port;
         end
         pending.push_back(o);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response port=%0d hit=%0d", a.out_port, a.hit);
            return;
         end
         e = pending.pop_front();
         if (a.out_port !== e.out_port || a.hit !== e.hit) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: port exp %0d got %0d, hit exp %0d got %0d",
                        e.out_port, a.out_port, e.hit, a.hit);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write = 1'b0;
   logic [CNT_W-1:0] csr_wdata = '0;

   flow_cache_sb sb;
   int unsigned  cycle_count = 0;
   int unsigned  hold_cycles = 0;
   int unsigned  n_lookup = 0, n_insert = 0, n_hits = 0;
   logic [KEY_W-1:0] recent_keys [16];

   localparam int unsigned CYCLE_LIMIT = 3_000_000;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   set_assoc_flow_cache_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_wdata(csr_wdata)
   );

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Response checking at the accepting edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_data.hit) n_hits++;
         sb.check_response(rsp_data);
      end
   end

   // Receiver stall pattern; hold_cycles forces a long stall stretch
   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (cycle_count[12:11] == 2'b11) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   // Offer one request and wait for it to be accepted
   task automatic send_request(input req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      if (r.command == CMD_LOOKUP) n_lookup++;
      else n_insert++;
   endtask

   task automatic idle_sender(input int unsigned n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_sets(input logic [CNT_W-1:0] v);
      csr_write <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.set_sets(v);
   endtask

   function automatic req_type make_req(logic cmd, logic [KEY_W-1:0] k, logic [PORT_W-1:0] p);
      req_type r;
      r.command = cmd;
      r.flow_key = k;
      r.insert_port = p;
      return r;
   endfunction

   // Random request biased toward keys that collide in few sets
   function automatic req_type rand_req(int unsigned sets);
      logic [KEY_W-1:0] k;
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) k = recent_keys[$urandom_range(0, 15)];
      else if (sel < 9) k = {$urandom(), 32'($urandom_range(0, 3 * sets))};
      else k = {$urandom(), $urandom()};
      if ($urandom_range(0, 2) == 0) recent_keys[$urandom_range(0, 15)] = k;
      return make_req(1'($urandom_range(0, 1)), k, 4'($urandom()));
   endfunction

   task automatic random_phase(input int unsigned count, input int unsigned sets);
      int unsigned burst;
      int unsigned sent;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_request(rand_req(sets));
            sent++;
         end
         if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 40));
      end
   endtask

   initial begin
      logic [CNT_W-1:0] settings [6];
      sb = new();
      sb.clear();
      foreach (recent_keys[i]) recent_keys[i] = {$urandom(), 32'($urandom_range(0, 7))};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: cleared ways hit on key 0, extremes, port 0, eviction
      send_request(make_req(CMD_LOOKUP, '0, 4'hF));
      send_request(make_req(CMD_LOOKUP, '1, '0));
      send_request(make_req(CMD_INSERT, '1, 4'hF));
      send_request(make_req(CMD_LOOKUP, '1, '0));
      send_request(make_req(CMD_INSERT, 64'h5555_AAAA_0000_0000, 4'h0));
      send_request(make_req(CMD_LOOKUP, 64'h5555_AAAA_0000_0000, 4'h3));
      send_request(make_req(CMD_INSERT, 64'hAAAA_5555_FFFF_FFFF, 4'hA));
      for (int i = 0; i < 6; i++)
         send_request(make_req(CMD_INSERT, 64'(i) << 40, 4'(i + 1)));
      send_request(make_req(CMD_LOOKUP, 64'd1 << 40, 4'h0));
      send_request(make_req(CMD_LOOKUP, 64'd5 << 40, 4'h0));
      drain();

      // Long receiver hold with the sender still offering: fill and back up
      hold_cycles <= 600;
      for (int i = 0; i < 20; i++) send_request(rand_req(1024));
      drain();

      // Walk set counts, extremes included; writes only while idle
      settings = '{11'd1, 11'd0, 11'd2047, 11'd7, 11'd1024, 11'd3};
      foreach (settings[s]) begin
         write_sets(settings[s]);
         // duplicates in one set: several ways share a key
         send_request(make_req(CMD_INSERT, 64'h99, 4'h4));
         send_request(make_req(CMD_INSERT, 64'h99, 4'h6));
         send_request(make_req(CMD_LOOKUP, 64'h99, 4'h0));
         random_phase(245, (settings[s] == 0) ? 1 : settings[s]);
         drain();
      end

      $display("tb_top: %0d lookups (%0d hits) and %0d inserts over %0d set-count settings",
               n_lookup, n_hits, n_insert, 6);
      $display("tb_top: %0d responses checked, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end
endmodule

/* filelist.f */
hdl/sac_pkg.sv
hdl/sac_ctrl.sv
hdl/sac_dp.sv
hdl/set_assoc_flow_cache_core.sv
hdl/sac_checker.sv
tb/tb_top.sv
